>>> src/srcs_pkg.sv
// Shared types, opcodes and constants of the sixteen-register processor step block.
package srcs_pkg;

  localparam int DATA_DEPTH = 65536;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int VALID_ROWS = DATA_DEPTH / 32;
  localparam int VALID_RW   = $clog2(VALID_ROWS);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_SLT  = 4'd2,
    OP_OR   = 4'd3,
    OP_NAND = 4'd4,
    OP_ADDI = 4'd5,
    OP_SLTI = 4'd6,
    OP_ORI  = 4'd7,
    OP_LUI  = 4'd8,
    OP_LW   = 4'd9,
    OP_SW   = 4'd10,
    OP_BEQ  = 4'd11,
    OP_JALR = 4'd12,
    OP_J    = 4'd13,
    OP_HALT = 4'd14,
    OP_NOP  = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    STOP_RUN   = 2'd0,
    STOP_HALT  = 2'd1,
    STOP_END   = 2'd2,
    STOP_RANGE = 2'd3
  } stop_t;

  localparam logic [0:0] REG_PROGRAM_LENGTH = 1'b0;

  typedef struct packed {
    logic          preload;
    opcode_t       op;
    logic [3:0]    rs;
    logic [3:0]    rt;
    logic [3:0]    rd;
    logic [15:0]   imm;
    logic [31:0]   word;
    logic [DATA_AW-1:0] load_addr;
  } item_t;

endpackage

>>> src/sixteen_register_cpu_step_top.sv
// Top level of the sixteen-register processor step block with its APB register port.
// Each execute or preload beat gives one result beat. Most beats load the result
// register as they execute; a lw loads it from the registered read of the data memory.
// A two-entry queue parts intake from execution and the result register parts
// execution from the output. After reset a clearing pass sweeps the DATA_DEPTH/32
// (2048) rows of word valid bits, one row of 32 a cycle; no beat is taken meanwhile.
module sixteen_register_cpu_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] word,
  input  logic [15:0] load_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic [1:0]  stop_code,
  output logic        reg_written,
  output logic [3:0]  reg_index,
  output logic [31:0] reg_value
);
  import srcs_pkg::*;

  logic [16:0] program_length;
  logic        q_valid;
  logic        q_take;
  item_t       q_item;
  logic        busy;
  logic        clearing;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_PROGRAM_LENGTH) ? {15'd0, program_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 17'd0;
    end else if (psel && penable && pwrite && paddr == REG_PROGRAM_LENGTH) begin
      program_length <= pwdata[16:0];
    end
  end

  srcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .word      (word),
    .load_addr (load_addr),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .hold      (clearing)
  );

  srcs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .q_item         (q_item),
    .program_length (program_length),
    .busy           (busy),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .next_pc        (next_pc),
    .stop_code      (stop_code),
    .reg_written    (reg_written),
    .reg_index      (reg_index),
    .reg_value      (reg_value)
  );

`ifndef SYNTHESIS
  a_no_take_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_take) else $error("queue drained during clearing pass");
  a_stall_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("stalled result dropped");
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");
  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result pending while idle");
`endif
endmodule

>>> src/srcs_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module srcs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [31:0]          word,
  input  logic [15:0]          load_addr,
  output logic                 q_valid,
  input  logic                 q_take,
  output srcs_pkg::item_t      q_item,
  input  logic                 hold
);
  import srcs_pkg::*;

  item_t          slots [QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  item_t          cls;
  logic           push;

  always_comb begin
    cls.preload   = func;
    cls.op        = opcode_t'(word[27:24]);
    cls.rs        = word[23:20];
    cls.rt        = word[19:16];
    cls.rd        = word[15:12];
    cls.imm       = word[15:0];
    cls.word      = word;
    cls.load_addr = load_addr[DATA_AW-1:0];
  end

  assign in_stall = hold || (count == 2'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_take);
    end
  end
endmodule

>>> src/srcs_back.sv
// Back end: register file, data memory with valid bits, pc and result register.
module srcs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  srcs_pkg::item_t      q_item,
  input  logic [16:0]          program_length,
  output logic                 busy,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          next_pc,
  output logic [1:0]           stop_code,
  output logic                 reg_written,
  output logic [3:0]           reg_index,
  output logic [31:0]          reg_value
);
  import srcs_pkg::*;

  logic [31:0]        regs [16];
  logic [31:0]        mem  [DATA_DEPTH];
  logic [31:0]        vmem [VALID_ROWS];
  logic [31:0]        pc;
  logic [VALID_RW:0]  clr_cnt;

  // pending load, completed from the registered memory read
  logic               ld_pend;
  logic [3:0]         ld_rt;
  logic [4:0]         ld_bit;
  logic [31:0]        mem_q;
  logic [31:0]        vrow_q;
  logic               ld_ok;

  logic               out_free;
  logic               exec;
  logic [31:0]        a, b, si, npc, wval, addr_full;
  logic               wr;
  logic [3:0]         widx;
  logic [DATA_AW-1:0] maddr;
  logic               mwr;
  logic [31:0]        mwdata;
  logic [VALID_RW-1:0] vidx;
  logic [1:0]         stop;
  logic               is_load;

  assign clearing = !clr_cnt[VALID_RW];
  assign out_free = !out_valid || !out_stall;
  assign exec     = q_valid && out_free && !ld_pend && !clearing;
  assign q_take   = exec;
  assign busy     = q_valid || ld_pend || out_valid;
  assign ld_ok    = vrow_q[ld_bit];

  assign a         = regs[q_item.rs];
  assign b         = regs[q_item.rt];
  assign si        = {{16{q_item.imm[15]}}, q_item.imm};
  assign addr_full = a + si;
  assign is_load   = !q_item.preload && (q_item.op == OP_LW);

  always_comb begin
    wr     = 1'b0;
    widx   = 4'd0;
    wval   = 32'd0;
    npc    = pc + 32'd1;
    mwr    = 1'b0;
    maddr  = addr_full[DATA_AW-1:0];
    mwdata = b;
    stop   = STOP_RUN;
    if (q_item.preload) begin
      npc   = pc;
      mwr   = 1'b1;
      maddr = q_item.load_addr;
      mwdata = q_item.word;
    end else begin
      unique case (q_item.op)
        OP_ADD:  begin wr = 1'b1; widx = q_item.rd; wval = a + b; end
        OP_SUB:  begin wr = 1'b1; widx = q_item.rd; wval = a - b; end
        OP_SLT:  begin wr = 1'b1; widx = q_item.rd; wval = 32'($signed(a) < $signed(b)); end
        OP_OR:   begin wr = 1'b1; widx = q_item.rd; wval = a | b; end
        OP_NAND: begin wr = 1'b1; widx = q_item.rd; wval = ~(a & b); end
        OP_ADDI: begin wr = 1'b1; widx = q_item.rt; wval = a + si; end
        OP_SLTI: begin wr = 1'b1; widx = q_item.rt; wval = 32'($signed(a) < $signed(si)); end
        OP_ORI:  begin wr = 1'b1; widx = q_item.rt; wval = a | si; end
        OP_LUI:  begin wr = 1'b1; widx = q_item.rt; wval = {q_item.imm, 16'd0}; end
        OP_LW:   begin end
        OP_SW:   mwr = 1'b1;
        OP_BEQ:  begin
          if (a == b) begin
            npc = pc + 32'd1 + si;
          end
        end
        OP_JALR: begin
          wr = 1'b1; widx = q_item.rt; wval = pc + 32'd1;
          npc = (q_item.rs == q_item.rt) ? pc + 32'd1 : a;
        end
        OP_J:    npc = {16'd0, q_item.imm};
        OP_HALT: stop = STOP_HALT;
        OP_NOP:  begin end
        default: begin end
      endcase
    end
    if (!q_item.preload && stop == STOP_RUN) begin
      if (npc == {15'd0, program_length}) begin
        stop = STOP_END;
      end else if (npc[31] || npc > {15'd0, program_length}) begin
        stop = STOP_RANGE;
      end
    end
  end

  assign vidx = maddr[DATA_AW-1:5];

  always_ff @(posedge clk) begin
    if (clearing) begin
      vmem[clr_cnt[VALID_RW-1:0]] <= 32'd0;
    end else if (exec && mwr) begin
      vmem[vidx][maddr[4:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && mwr) begin
      mem[maddr] <= mwdata;
    end
    mem_q  <= mem[maddr];
    vrow_q <= vmem[vidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        regs[i] <= 32'd0;
      end
    end else if (exec && wr) begin
      regs[widx] <= wval;
    end else if (ld_pend && ld_ok) begin
      regs[ld_rt] <= mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 32'd0;
      clr_cnt   <= '0;
      ld_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (ld_pend) begin
        ld_pend   <= 1'b0;
        out_valid <= 1'b1;
      end
      if (exec) begin
        pc <= npc;
        if (is_load) begin
          ld_pend <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      ld_rt       <= q_item.rt;
      ld_bit      <= maddr[4:0];
      next_pc     <= npc;
      stop_code   <= stop;
      reg_written <= wr;
      reg_index   <= wr ? widx : 4'd0;
      reg_value   <= wr ? wval : 32'd0;
    end else if (ld_pend) begin
      reg_written <= ld_ok;
      reg_index   <= ld_ok ? ld_rt : 4'd0;
      reg_value   <= ld_ok ? mem_q : 32'd0;
    end
  end
endmodule
